[rtl/qenc_pkg.sv]
// Shared types and constants for the dual quadrature position counter.
// No dependencies; used by qenc_wheel and the top level.
package qenc_pkg;

   // Width of every count field on the result channel
   localparam int unsigned OUT_WIDTH = 32;

   // Operation codes carried on the request channel
   typedef enum logic [1:0] {
      OP_EDGE       = 2'd0,
      OP_TICK       = 2'd1,
      OP_CLR_TOTALS = 2'd2,
      OP_CLR_ALL    = 2'd3
   } op_type;

   // Per-wheel command presented to one counter slice
   typedef struct packed {
      op_type op;
      logic   edge_a;
      logic   edge_b;
      logic   level_a;
      logic   level_b;
   } wheel_cmd_type;

endpackage

[rtl/qenc_wheel.sv]
// One wheel's counter slice: edge window, latched speed and running total.
// Depends on qenc_pkg for the command struct and operation codes.
module qenc_wheel #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  qenc_pkg::wheel_cmd_type    cmd,
   input  logic                       invert,
   output logic [COUNT_WIDTH-1:0]     latched,
   output logic [COUNT_WIDTH-1:0]     total
);

   logic [COUNT_WIDTH-1:0] window_ff, window_in;
   logic [COUNT_WIDTH-1:0] latched_ff, latched_in;
   logic [COUNT_WIDTH-1:0] sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] step;
   logic [COUNT_WIDTH-1:0] snap;
   logic                   move;
   logic                   up;

   // Decode direction: A edge wins over B edge
   always_comb begin
      move = cmd.edge_a | cmd.edge_b;
      up   = cmd.edge_a ? cmd.level_b : ~cmd.level_a;
      // +1 when counting up, all ones (-1) when counting down
      step = {{(COUNT_WIDTH-1){~up}}, 1'b1};
      snap = invert ? ('0 - window_ff) : window_ff;
   end

   // Next state per operation
   always_comb begin
      window_in  = window_ff;
      latched_in = latched_ff;
      sum_in     = sum_ff;
      unique case (cmd.op)
         qenc_pkg::OP_EDGE: begin
            if (move) begin
               window_in = window_ff + step;
            end
         end
         qenc_pkg::OP_TICK: begin
            latched_in = snap;
            sum_in     = sum_ff + snap;
            window_in  = '0;
         end
         qenc_pkg::OP_CLR_TOTALS: begin
            sum_in = '0;
         end
         qenc_pkg::OP_CLR_ALL: begin
            window_in  = '0;
            latched_in = '0;
            sum_in     = '0;
         end
         default: begin
            window_in = window_ff;
         end
      endcase
   end

   // Update counters only when a transaction advances
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         latched_ff <= '0;
         sum_ff     <= '0;
      end else if (load) begin
         window_ff  <= window_in;
         latched_ff <= latched_in;
         sum_ff     <= sum_in;
      end
   end

   assign latched = latched_ff;
   assign total   = sum_ff;

endmodule

[rtl/dual_quadrature_speed_position_counter.sv]
// Top level of the dual quadrature speed and position counter.
// Depends on qenc_pkg and qenc_wheel (one instance per wheel).
//
// Usage:
//   Request channel (req_valid/req_ready) carries one event per transaction:
//   an edge event with per-pin edge flags and pin levels, a sample tick,
//   a clear of the totals, or a clear of everything.
//   Response channel (rsp_valid/rsp_ready) returns one transaction per
//   request: both latched speeds and both running totals after that event.
//   The right speed, and so the right total, is negated since that wheel is mounted in reverse.
//   An accepted request is registered in the request register, then applied
//   to the counters when it advances, which also sets the response valid;
//   the response then holds until rsp_ready takes it.
//   Throughput: one transaction per cycle while rsp_ready holds; the request
//   register and the counter registers form a two-entry pipeline, so a new
//   request is taken while a finished response still waits.
//   When the receiver stalls, the response holds and the pipeline fills;
//   req_ready falls only when both the request register and the response
//   are occupied.
//   Reset clears all counters to zero and empties the pipeline.
//   Counters are COUNT_WIDTH bits, wrap in two's complement and are
//   sign-extended or truncated to 32 bits on the response.
module dual_quadrature_speed_position_counter #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic                req_edge_left_a,
   input  logic                req_edge_left_b,
   input  logic                req_edge_right_a,
   input  logic                req_edge_right_b,
   input  logic                req_level_left_a,
   input  logic                req_level_left_b,
   input  logic                req_level_right_a,
   input  logic                req_level_right_b,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_speed_left,
   output logic signed [31:0]  rsp_speed_right,
   output logic signed [31:0]  rsp_total_left,
   output logic signed [31:0]  rsp_total_right
);

   localparam int unsigned OW = qenc_pkg::OUT_WIDTH;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   qenc_pkg::op_type        s1_op_ff;
   logic [3:0]              s1_edge_ff;
   logic [3:0]              s1_level_ff;
   logic                    advance;
   logic                    take;
   qenc_pkg::wheel_cmd_type cmd_left, cmd_right;
   logic [COUNT_WIDTH-1:0]  latched_left, latched_right;
   logic [COUNT_WIDTH-1:0]  sum_left, sum_right;

   // Handshake: advance when the response slot is free or being drained
   always_comb begin
      advance      = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
      req_ready    = ~s1_valid_ff | advance;
      take         = req_valid & req_ready;
      s1_valid_in  = take | (s1_valid_ff & ~advance);
      rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);
   end

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture request payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_op_ff    <= qenc_pkg::op_type'(req_op);
         s1_edge_ff  <= {req_edge_right_b, req_edge_right_a,
                         req_edge_left_b, req_edge_left_a};
         s1_level_ff <= {req_level_right_b, req_level_right_a,
                         req_level_left_b, req_level_left_a};
      end
   end

   // Split registered request into per-wheel commands
   always_comb begin
      cmd_left.op       = s1_op_ff;
      cmd_left.edge_a   = s1_edge_ff[0];
      cmd_left.edge_b   = s1_edge_ff[1];
      cmd_left.level_a  = s1_level_ff[0];
      cmd_left.level_b  = s1_level_ff[1];
      cmd_right.op      = s1_op_ff;
      cmd_right.edge_a  = s1_edge_ff[2];
      cmd_right.edge_b  = s1_edge_ff[3];
      cmd_right.level_a = s1_level_ff[2];
      cmd_right.level_b = s1_level_ff[3];
   end

   qenc_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
      .clock   (clock),
      .reset   (reset),
      .load    (advance),
      .cmd     (cmd_left),
      .invert  (1'b0),
      .latched (latched_left),
      .total   (sum_left)
   );

   qenc_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
      .clock   (clock),
      .reset   (reset),
      .load    (advance),
      .cmd     (cmd_right),
      .invert  (1'b1),
      .latched (latched_right),
      .total   (sum_right)
   );

   // Fit counters to the 32-bit response fields
   generate
      if (COUNT_WIDTH >= OW) begin : g_trunc
         assign rsp_speed_left  = latched_left[OW-1:0];
         assign rsp_speed_right = latched_right[OW-1:0];
         assign rsp_total_left  = sum_left[OW-1:0];
         assign rsp_total_right = sum_right[OW-1:0];
      end else begin : g_sext
         assign rsp_speed_left  = {{(OW-COUNT_WIDTH){latched_left[COUNT_WIDTH-1]}},
                                   latched_left};
         assign rsp_speed_right = {{(OW-COUNT_WIDTH){latched_right[COUNT_WIDTH-1]}},
                                   latched_right};
         assign rsp_total_left  = {{(OW-COUNT_WIDTH){sum_left[COUNT_WIDTH-1]}},
                                   sum_left};
         assign rsp_total_right = {{(OW-COUNT_WIDTH){sum_right[COUNT_WIDTH-1]}},
                                   sum_right};
      end
   endgenerate

   assign rsp_valid = rsp_valid_ff;

   // Backpressure only when both pipeline slots are full and stalled
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled with a free pipeline slot");

   // A full clear leaves every response field at zero
   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_op_ff == qenc_pkg::OP_CLR_ALL) |=>
         (rsp_speed_left == 0 && rsp_speed_right == 0 &&
          rsp_total_left == 0 && rsp_total_right == 0))
      else $error("counters not cleared by clear-all");

   // Clearing totals keeps the latched speeds
   a_clear_totals: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_op_ff == qenc_pkg::OP_CLR_TOTALS) |=>
         (rsp_total_left == 0 && rsp_total_right == 0 &&
          $stable(rsp_speed_left) && $stable(rsp_speed_right)))
      else $error("clear-totals result mismatch");

   // Every advanced transaction yields a pending response
   a_rsp_after_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("response missing after advance");

endmodule
